/* sv/itf_pkg.sv */
// Shared types, constants and a helper function of the integer-to-text formatter.
// No dependencies; the digit unit, the formatter and its testbench import this package.

package itf_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_WIDTH_DEF  = 64;

    // Conversion modes as carried on the request channel
    typedef enum logic [2:0] {
        MODE_SDEC = 3'd0,
        MODE_UDEC = 3'd1,
        MODE_OCT  = 3'd2,
        MODE_HEXL = 3'd3,
        MODE_HEXU = 3'd4,
        MODE_PTR  = 3'd5
    } itf_mode_t;

    // Number base used by the digit unit
    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } itf_radix_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_LOAD = 3'd1,
        ST_CONV = 3'd2,
        ST_SCAN = 3'd3,
        ST_PLAN = 3'd4,
        ST_EMIT = 3'd5
    } itf_state_t;

    // Commands from the sequencer to the digit unit
    typedef struct packed {
        logic       load;
        itf_radix_t radix;
        logic       dabble;
        logic       shift;
    } itf_dig_cmd_t;

    // ASCII characters of the field
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    localparam logic [8*16-1:0] UPPER_DIGITS = "0123456789ABCDEF";
    localparam logic [8*16-1:0] LOWER_DIGITS = "0123456789abcdef";

    // Map one digit to its ASCII character; the first string character sits at the MSB
    function automatic logic [7:0] itf_digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] pos;
        pos = {4'(4'd15 - d), 3'b000};
        return upper ? UPPER_DIGITS[pos +: 8] : LOWER_DIGITS[pos +: 8];
    endfunction

endpackage

/* sv/itf_if.sv */
// Handshake channels of the integer-to-text formatter: conversion requests in,
// characters out. Standalone; no package needed.

interface itf_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        mode;
    logic [63:0]       value;
    logic [1:0]        arg_size;
    logic              left_align;
    logic              force_plus;
    logic              space_sign;
    logic              alternate_form;
    logic              zero_pad;
    logic [6:0]        field_width;
    logic signed [6:0] precision;

    modport source (
        output valid, mode, value, arg_size, left_align, force_plus, space_sign,
               alternate_form, zero_pad, field_width, precision,
        input  ready
    );
    modport sink (
        input  valid, mode, value, arg_size, left_align, force_plus, space_sign,
               alternate_form, zero_pad, field_width, precision,
        output ready
    );
endinterface

interface itf_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, character, last, input ready);
    modport sink (input valid, character, last, output ready);
endinterface

/* sv/itf_digit_unit.sv */
// Shared digit unit: holds the digit register, loads octal/hex digits directly,
// converts binary to decimal by shift-and-add-3, shifts digits out MSB first. Uses itf_pkg.

module itf_digit_unit #(
    parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  itf_pkg::itf_dig_cmd_t             cmd,
    input  logic [VALUE_BITS-1:0]             mag,
    input  logic [$clog2(VALUE_BITS+1)-1:0]   bits,
    output logic [3:0]                        top_digit
);
    import itf_pkg::*;

    localparam int DIGITS = (VALUE_BITS + 2) / 3;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int BITS_W = $clog2(VALUE_BITS + 1);

    logic [BCD_W-1:0]      dig_reg, dig_next;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]      mag_pad;
    logic [BCD_W-1:0]      oct_digits;
    logic [BCD_W-1:0]      adj_digits;
    logic [BITS_W-1:0]     skip;

    assign mag_pad = BCD_W'(mag);
    assign skip    = BITS_W'(VALUE_BITS) - bits;

    // Split into octal digits and pre-correct each BCD digit for the next doubling
    for (genvar i = 0; i < DIGITS; i++) begin : g_digit
        assign oct_digits[4*i +: 4] = {1'b0, mag_pad[3*i +: 3]};
        assign adj_digits[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ?
                                      4'(dig_reg[4*i +: 4] + 4'd3) : dig_reg[4*i +: 4];
    end

    // Select the next digit and binary contents
    always_comb
    begin
        dig_next = dig_reg;
        bin_next = bin_reg;
        if (cmd.load)
        begin
            bin_next = mag << skip;
            case (cmd.radix)
                RADIX_OCT: dig_next = oct_digits;
                RADIX_HEX: dig_next = mag_pad;
                default:   dig_next = '0;
            endcase
        end
        else if (cmd.dabble)
        begin
            dig_next = {adj_digits[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
            bin_next = bin_reg << 1;
        end
        else if (cmd.shift)
        begin
            dig_next = dig_reg << 4;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        bin_reg <= bin_next;
    end

    assign top_digit = dig_reg[BCD_W-1 -: 4];

endmodule

/* sv/itf_out_stage.sv */
// Output register of the formatter: holds one character until the sink takes it.
// Depends on itf_text_if.

module itf_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    ch_in,
    input  logic          last_in,
    output logic          can_push,
    itf_text_if.source    text
);
    logic       valid_reg, valid_next;
    logic [7:0] ch_reg;
    logic       last_reg;

    // Room when empty or when the held character leaves this cycle
    assign can_push = !valid_reg || text.ready;

    always_comb
    begin
        if (push)
            valid_next = 1'b1;
        else if (text.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the payload on each push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ch_reg   <= ch_in;
            last_reg <= last_in;
        end
    end

    assign text.valid     = valid_reg;
    assign text.character = ch_reg;
    assign text.last      = last_reg;

endmodule

/* sv/integer_to_text_formatter.sv */
// integer_to_text_formatter: printf-style %d %u %o %x %X %p conversion of one integer per
// request, streamed out as ASCII characters with the final one marked by last. The block takes
// one request at a time: after a transfer it runs a load step, then for decimal modes a per-bit
// pass over the argument bits (8 to VALUE_BITS) in the shared shift-and-add-3 digit unit, then a
// scan through the same unit that drops leading zero digits, a planning step, and the emission
// of each character (up to MAX_WIDTH) as the sink takes it; the request channel is ready again
// in the cycle after the last character, or after the planning step when the field is empty.
// Hex and octal skip the per-bit pass.
// Depends on itf_pkg, itf_if, itf_digit_unit and itf_out_stage.

module integer_to_text_formatter #(
    parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF,
    parameter int MAX_WIDTH  = itf_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    itf_req_if.sink     req,
    itf_text_if.source  text
);
    import itf_pkg::*;

    localparam int DIGITS     = (VALUE_BITS + 2) / 3;
    localparam int DIG_CW     = $clog2(DIGITS + 1);
    localparam int BITS_W     = $clog2(VALUE_BITS + 1);
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
    localparam int PREC_LIMIT = MAX_WIDTH - 4;

    typedef enum logic [2:0] {
        PH_LPAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_PFX   = 3'd2,
        PH_ZERO  = 3'd3,
        PH_DIGIT = 3'd4,
        PH_RPAD  = 3'd5
    } itf_phase_t;

    itf_state_t state_reg, state_next;

    // Request fields held for the conversion
    logic [VALUE_BITS-1:0] mag_reg;
    logic [BITS_W-1:0]     bits_reg;
    itf_radix_t            radix_reg;
    logic                  upper_reg;
    logic                  ptr_reg;
    logic                  alt_reg;
    logic                  left_reg;
    logic                  zpad_reg;
    logic                  zero_reg;
    logic                  has_sign_reg;
    logic [7:0]            sign_char_reg;
    logic [CNT_W-1:0]      width_reg;
    logic [CNT_W-1:0]      prec_reg;
    logic                  prec_spec_reg;

    // Sequencer counters
    logic [BITS_W-1:0] conv_cnt_reg, conv_cnt_next;
    logic [DIG_CW-1:0] ndig_reg, ndig_next;
    logic [CNT_W-1:0]  lpad_cnt_reg, lpad_cnt_next;
    logic [CNT_W-1:0]  rpad_cnt_reg, rpad_cnt_next;
    logic [CNT_W-1:0]  zero_cnt_reg, zero_cnt_next;
    logic [1:0]        pfx_cnt_reg, pfx_cnt_next;
    logic              pfx_hex_reg, pfx_hex_next;
    logic              sign_pend_reg, sign_pend_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;

    // Request decode
    logic [6:0]            size_bits;
    logic                  ptr_in;
    logic                  sdec_in;
    logic                  upper_in;
    itf_radix_t            radix_in;
    logic [BITS_W-1:0]     bits_in;
    logic [VALUE_BITS-1:0] mask_in;
    logic [VALUE_BITS-1:0] raw_in;
    logic                  neg_in;
    logic [VALUE_BITS-1:0] mag_in;
    logic                  has_sign_in;
    logic [7:0]            sign_char_in;
    logic [CNT_W-1:0]      width_in;
    logic [CNT_W-1:0]      prec_in;
    logic                  prec_spec_in;
    logic                  accept;

    // Plan of the field
    logic [CNT_W-1:0] ndig_eff;
    logic [CNT_W-1:0] zeros0;
    logic             pfx_hex_p;
    logic             pfx_oct_p;
    logic [1:0]       pfx_len_p;
    logic [CNT_W-1:0] total0;
    logic             zfill;
    logic [CNT_W-1:0] zeros_p;
    logic [CNT_W-1:0] total_p;
    logic [CNT_W-1:0] pad_p;
    logic [CNT_W-1:0] remain_p;

    // Emission and digit unit control
    itf_phase_t   phase;
    logic         can_push;
    logic         emit_go;
    logic         push;
    logic [7:0]   ch;
    logic         last_ch;
    logic         scan_shift;
    logic [3:0]   top_digit;
    itf_dig_cmd_t dig_cmd;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Decode mode and argument size
    always_comb
    begin
        sdec_in  = 1'b0;
        upper_in = 1'b0;
        ptr_in   = 1'b0;
        radix_in = RADIX_DEC;
        unique case (req.mode)
            MODE_SDEC: sdec_in = 1'b1;
            MODE_UDEC: radix_in = RADIX_DEC;
            MODE_OCT:  radix_in = RADIX_OCT;
            MODE_HEXL: radix_in = RADIX_HEX;
            MODE_HEXU:
            begin
                radix_in = RADIX_HEX;
                upper_in = 1'b1;
            end
            MODE_PTR:
            begin
                radix_in = RADIX_HEX;
                ptr_in   = 1'b1;
            end
            default:   radix_in = RADIX_DEC;
        endcase
    end

    // Reduce to the argument width and take the magnitude
    assign size_bits = 7'd8 << req.arg_size;
    assign bits_in   = (ptr_in || size_bits > 7'(VALUE_BITS)) ? BITS_W'(VALUE_BITS)
                                                              : BITS_W'(size_bits);
    assign mask_in   = {VALUE_BITS{1'b1}} >> (BITS_W'(VALUE_BITS) - bits_in);
    assign raw_in    = req.value[VALUE_BITS-1:0] & mask_in;
    assign neg_in    = sdec_in && raw_in[IDX_W'(bits_in - BITS_W'(1))];
    assign mag_in    = neg_in ? ((~raw_in + VALUE_BITS'(1)) & mask_in) : raw_in;

    // Pick the sign character; plus wins over space
    always_comb
    begin
        has_sign_in  = sdec_in;
        sign_char_in = CH_SPACE;
        if (neg_in)
            sign_char_in = CH_MINUS;
        else if (req.force_plus)
            sign_char_in = CH_PLUS;
        else if (req.space_sign)
            sign_char_in = CH_SPACE;
        else
            has_sign_in = 1'b0;
    end

    // Saturate width and precision; a pointer without precision gets one digit
    assign width_in = (req.field_width > 7'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH)
                                                        : CNT_W'(req.field_width);
    always_comb
    begin
        prec_spec_in = !req.precision[6];
        if ({1'b0, req.precision[5:0]} > 7'(PREC_LIMIT))
            prec_in = CNT_W'(PREC_LIMIT);
        else
            prec_in = CNT_W'(req.precision[5:0]);
        if (ptr_in && !prec_spec_in)
        begin
            prec_spec_in = 1'b1;
            prec_in      = CNT_W'(1);
        end
    end

    // Hold the decoded request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg       <= mag_in;
            bits_reg      <= bits_in;
            radix_reg     <= radix_in;
            upper_reg     <= upper_in;
            ptr_reg       <= ptr_in;
            alt_reg       <= req.alternate_form || ptr_in;
            left_reg      <= req.left_align;
            zpad_reg      <= req.zero_pad;
            zero_reg      <= (mag_in == '0);
            has_sign_reg  <= has_sign_in;
            sign_char_reg <= sign_char_in;
            width_reg     <= width_in;
            prec_reg      <= prec_in;
            prec_spec_reg <= prec_spec_in;
        end
    end

    // Lay out the field once the digit count is known
    always_comb
    begin
        ndig_eff  = (zero_reg && prec_spec_reg && prec_reg == '0) ? '0 : CNT_W'(ndig_reg);
        zeros0    = (prec_spec_reg && prec_reg > ndig_eff) ? (prec_reg - ndig_eff) : '0;
        pfx_hex_p = alt_reg && (radix_reg == RADIX_HEX) &&
                    (ptr_reg ? (ndig_eff != '0) : !zero_reg);
        pfx_oct_p = alt_reg && (radix_reg == RADIX_OCT) && (zeros0 == '0) &&
                    !(zero_reg && ndig_eff != '0);
        pfx_len_p = pfx_hex_p ? 2'd2 : (pfx_oct_p ? 2'd1 : 2'd0);
        total0    = ndig_eff + zeros0 + CNT_W'(pfx_len_p) + CNT_W'(has_sign_reg);
        zfill     = zpad_reg && !left_reg && !prec_spec_reg && (width_reg > total0);
        zeros_p   = zfill ? (zeros0 + (width_reg - total0)) : zeros0;
        total_p   = zfill ? width_reg : total0;
        pad_p     = (width_reg > total_p) ? (width_reg - total_p) : '0;
        remain_p  = total_p + pad_p;
    end

    assign scan_shift = (state_reg == ST_SCAN) && (ndig_reg > DIG_CW'(1)) && (top_digit == 4'd0);
    assign emit_go    = (state_reg == ST_EMIT) && can_push;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LOAD;
            ST_LOAD: state_next = (radix_reg == RADIX_DEC) ? ST_CONV : ST_SCAN;
            ST_CONV: if (conv_cnt_reg == BITS_W'(1)) state_next = ST_SCAN;
            ST_SCAN: if (!scan_shift) state_next = ST_PLAN;
            ST_PLAN: state_next = (remain_p == '0) ? ST_IDLE : ST_EMIT;
            ST_EMIT: if (emit_go && remain_reg == CNT_W'(1)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Select the field part that comes next
    always_comb
    begin
        if (lpad_cnt_reg != '0)
            phase = PH_LPAD;
        else if (sign_pend_reg)
            phase = PH_SIGN;
        else if (pfx_cnt_reg != 2'd0)
            phase = PH_PFX;
        else if (zero_cnt_reg != '0)
            phase = PH_ZERO;
        else if (ndig_reg != '0)
            phase = PH_DIGIT;
        else
            phase = PH_RPAD;
    end

    // Outputs: digit unit commands, character and push
    always_comb
    begin
        dig_cmd        = '0;
        dig_cmd.radix  = radix_reg;
        dig_cmd.load   = (state_reg == ST_LOAD);
        dig_cmd.dabble = (state_reg == ST_CONV);
        dig_cmd.shift  = scan_shift || (emit_go && phase == PH_DIGIT);

        push    = emit_go;
        last_ch = (remain_reg == CNT_W'(1));
        unique case (phase)
            PH_LPAD:  ch = CH_SPACE;
            PH_SIGN:  ch = sign_char_reg;
            PH_PFX:   ch = (pfx_cnt_reg == 2'd1 && pfx_hex_reg) ? (upper_reg ? CH_UX : CH_LX)
                                                                : CH_ZERO;
            PH_ZERO:  ch = CH_ZERO;
            PH_DIGIT: ch = itf_digit_char(top_digit, upper_reg);
            PH_RPAD:  ch = CH_SPACE;
            default:  ch = CH_SPACE;
        endcase
    end

    // Counter updates
    always_comb
    begin
        conv_cnt_next  = conv_cnt_reg;
        ndig_next      = ndig_reg;
        lpad_cnt_next  = lpad_cnt_reg;
        rpad_cnt_next  = rpad_cnt_reg;
        zero_cnt_next  = zero_cnt_reg;
        pfx_cnt_next   = pfx_cnt_reg;
        pfx_hex_next   = pfx_hex_reg;
        sign_pend_next = sign_pend_reg;
        remain_next    = remain_reg;
        case (state_reg)
            ST_LOAD:
            begin
                conv_cnt_next = bits_reg;
                ndig_next     = DIG_CW'(DIGITS);
            end
            ST_CONV:
            begin
                conv_cnt_next = conv_cnt_reg - BITS_W'(1);
            end
            ST_SCAN:
            begin
                if (scan_shift)
                    ndig_next = ndig_reg - DIG_CW'(1);
            end
            ST_PLAN:
            begin
                ndig_next      = DIG_CW'(ndig_eff);
                lpad_cnt_next  = left_reg ? '0 : pad_p;
                rpad_cnt_next  = left_reg ? pad_p : '0;
                zero_cnt_next  = zeros_p;
                pfx_cnt_next   = pfx_len_p;
                pfx_hex_next   = pfx_hex_p;
                sign_pend_next = has_sign_reg;
                remain_next    = remain_p;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    remain_next = remain_reg - CNT_W'(1);
                    case (phase)
                        PH_LPAD:  lpad_cnt_next  = lpad_cnt_reg - CNT_W'(1);
                        PH_SIGN:  sign_pend_next = 1'b0;
                        PH_PFX:   pfx_cnt_next   = pfx_cnt_reg - 2'd1;
                        PH_ZERO:  zero_cnt_next  = zero_cnt_reg - CNT_W'(1);
                        PH_DIGIT: ndig_next      = ndig_reg - DIG_CW'(1);
                        default:  rpad_cnt_next  = rpad_cnt_reg - CNT_W'(1);
                    endcase
                end
            end
            default:
            begin
                remain_next = remain_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            conv_cnt_reg  <= '0;
            ndig_reg      <= '0;
            lpad_cnt_reg  <= '0;
            rpad_cnt_reg  <= '0;
            zero_cnt_reg  <= '0;
            pfx_cnt_reg   <= '0;
            pfx_hex_reg   <= 1'b0;
            sign_pend_reg <= 1'b0;
            remain_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            conv_cnt_reg  <= conv_cnt_next;
            ndig_reg      <= ndig_next;
            lpad_cnt_reg  <= lpad_cnt_next;
            rpad_cnt_reg  <= rpad_cnt_next;
            zero_cnt_reg  <= zero_cnt_next;
            pfx_cnt_reg   <= pfx_cnt_next;
            pfx_hex_reg   <= pfx_hex_next;
            sign_pend_reg <= sign_pend_next;
            remain_reg    <= remain_next;
        end
    end

    itf_digit_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digit (
        .clk       (clk),
        .cmd       (dig_cmd),
        .mag       (mag_reg),
        .bits      (bits_reg),
        .top_digit (top_digit)
    );

    itf_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .ch_in    (ch),
        .last_in  (last_ch),
        .can_push (can_push),
        .text     (text)
    );

`ifndef ASSERT_OFF
    // The marked final character ends the conversion
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (push && last_ch) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the last character");

    // The remaining count matches the sum of the field parts still to send
    a_remain_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (remain_reg == CNT_W'(lpad_cnt_reg + rpad_cnt_reg +
            zero_cnt_reg + CNT_W'(pfx_cnt_reg) + CNT_W'(sign_pend_reg) + CNT_W'(ndig_reg))))
        else $error("remaining character count disagrees with the field parts");

    // Only decimal requests run the per-bit conversion
    a_conv_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (radix_reg == RADIX_DEC))
        else $error("binary-to-decimal pass started for a non-decimal request");

    // A digit is shifted out only while digits remain
    a_digit_left: assert property (@(posedge clk) disable iff (!rst_n)
        (push && phase == PH_DIGIT) |-> (ndig_reg != '0))
        else $error("digit emitted with an empty digit count");
`endif

endmodule

/* tb/sv/integer_to_text_formatter_tb.sv */
// Self-checking testbench for integer_to_text_formatter: drives printf-style conversion
// requests and checks every emitted character against an in-bench formatter model.
// Depends on itf_pkg, itf_if and the formatter RTL.

module integer_to_text_formatter_tb;

    import itf_pkg::*;

    localparam int MAX_FIELD   = 64;
    localparam int PREC_CAP    = MAX_FIELD - 4;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 250;
    localparam int MAX_REPORTS = 40;
    localparam int RANDOM_REQS = 155;

    // Receiver long hold-off windows, in cycles after reset
    localparam int HOLD_A_START = 2500;
    localparam int HOLD_B_START = 9000;
    localparam int HOLD_LEN     = 600;

    // Mode codes outside the enum; the block treats them as unsigned decimal
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    // Flag bits for directed requests: {left, plus, space, alternate, zero pad}
    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_LEFT  = 5'b10000;
    localparam logic [4:0] F_PLUS  = 5'b01000;
    localparam logic [4:0] F_SPACE = 5'b00100;
    localparam logic [4:0] F_ALT   = 5'b00010;
    localparam logic [4:0] F_ZPAD  = 5'b00001;

    localparam int PREC_NONE = -1;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] value;
        logic [1:0]  arg_size;
        logic        left_align;
        logic        force_plus;
        logic        space_sign;
        logic        alternate_form;
        logic        zero_pad;
        logic [6:0]  field_width;
        logic [6:0]  precision;
    } conv_req_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } text_beat_t;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_style_t;

    logic clk;
    logic rst_n;

    itf_req_if  req ();
    itf_text_if text ();

    integer_to_text_formatter u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .text  (text)
    );

    conv_req_t  pending_reqs[$];
    bit         pending_drain[$];
    text_beat_t expected_chars[$];

    int fail_count;
    int report_count;
    int char_index;

    // Count a failure and print it while under the report cap
    function automatic void note_failure(input string msg);
        fail_count++;
        if (report_count < MAX_REPORTS)
        begin
            $display("%0t: %s", $time, msg);
            report_count++;
        end
    endfunction

    // Build the expected character stream of one conversion request
    function automatic void predict_field(input conv_req_t r);
        int         width;
        int         prec;
        int         bits;
        int         base;
        int         ndig;
        int         zeros;
        int         total;
        int         pad;
        int         n;
        int         d;
        logic [63:0] mask;
        logic [63:0] mag;
        logic [63:0] rem;
        logic [7:0]  sign_ch;
        logic [7:0]  digits[$];
        logic [7:0]  prefix[$];
        logic [7:0]  field[$];
        bit          upper;
        bit          alt;
        bit          has_sign;
        text_beat_t  beat;

        width = (r.field_width > MAX_FIELD) ? MAX_FIELD : int'(r.field_width);
        prec = r.precision[6] ? -1 : int'(r.precision);
        if (prec > PREC_CAP)
            prec = PREC_CAP;

        bits = 8 << r.arg_size;
        if (r.mode == MODE_PTR)
            bits = 64;
        mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
        mag = r.value & mask;

        base = 10;
        upper = 1'b0;
        alt = r.alternate_form;
        has_sign = 1'b0;
        sign_ch = CH_SPACE;

        // Sign handling and radix selection
        case (r.mode)
            MODE_SDEC:
            begin
                if (mag[bits-1])
                begin
                    mag = (~mag + 64'd1) & mask;
                    has_sign = 1'b1;
                    sign_ch = CH_MINUS;
                end
                else if (r.force_plus)
                begin
                    has_sign = 1'b1;
                    sign_ch = CH_PLUS;
                end
                else if (r.space_sign)
                begin
                    has_sign = 1'b1;
                    sign_ch = CH_SPACE;
                end
            end
            MODE_OCT:
                base = 8;
            MODE_HEXL, MODE_HEXU, MODE_PTR:
            begin
                base = 16;
                upper = (r.mode == MODE_HEXU);
                if (r.mode == MODE_PTR)
                begin
                    alt = 1'b1;
                    if (prec < 0)
                        prec = 1;
                end
            end
            default: ;
        endcase

        // Digits, most significant first
        if (mag == 64'd0)
        begin
            if (prec != 0)
                digits.push_front(CH_ZERO);
        end
        else
        begin
            rem = mag;
            while (rem != 64'd0)
            begin
                d = int'(rem % base);
                if (d < 10)
                    digits.push_front(8'(CH_ZERO + d));
                else
                    digits.push_front(8'((upper ? CH_UPPER_A : CH_LOWER_A) + d - 10));
                rem = rem / base;
            end
        end
        ndig = digits.size();
        zeros = (prec > ndig) ? prec - ndig : 0;

        // Alternate-form prefix
        if (alt && base == 16)
        begin
            if ((r.mode == MODE_PTR) ? (ndig != 0) : (mag != 64'd0))
            begin
                prefix.push_back(CH_ZERO);
                prefix.push_back(upper ? CH_UX : CH_LX);
            end
        end
        else if (alt && r.mode == MODE_OCT)
        begin
            if (zeros == 0 && (ndig == 0 || digits[0] != CH_ZERO))
                prefix.push_back(CH_ZERO);
        end

        total = ndig + zeros + prefix.size() + (has_sign ? 1 : 0);
        if (r.zero_pad && !r.left_align && prec < 0 && width > total)
        begin
            zeros += width - total;
            total = width;
        end
        pad = (width > total) ? width - total : 0;

        // Assemble the field in output order
        if (!r.left_align)
            repeat (pad) field.push_back(CH_SPACE);
        if (has_sign)
            field.push_back(sign_ch);
        foreach (prefix[i])
            field.push_back(prefix[i]);
        repeat (zeros) field.push_back(CH_ZERO);
        foreach (digits[i])
            field.push_back(digits[i]);
        if (r.left_align)
            repeat (pad) field.push_back(CH_SPACE);

        n = (field.size() > MAX_FIELD) ? MAX_FIELD : field.size();
        for (int i = 0; i < n; i++)
        begin
            beat.character = field[i];
            beat.last = (i == n - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    // Queue one directed request
    function automatic void add_request(input logic [2:0] mode, input logic [63:0] value,
                                        input logic [1:0] arg_size, input logic [4:0] flags,
                                        input int width, input int prec);
        conv_req_t r;
        r.mode = mode;
        r.value = value;
        r.arg_size = arg_size;
        {r.left_align, r.force_plus, r.space_sign, r.alternate_form, r.zero_pad} = flags;
        r.field_width = 7'(width);
        r.precision = 7'(prec);
        pending_reqs.push_back(r);
        pending_drain.push_back(1'b0);
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Request driver: bursts of random length separated by random gaps
    int        burst_left;
    int        gap_left;
    bit        offer;
    conv_req_t next_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            offer = 1'b0;
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_reqs.size() != 0 &&
                     !(pending_drain[0] && (req.valid || expected_chars.size() != 0)))
            begin
                offer = 1'b1;
                next_req = pending_reqs.pop_front();
                void'(pending_drain.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 10);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            req.valid <= offer;
            if (offer)
            begin
                req.mode <= next_req.mode;
                req.value <= next_req.value;
                req.arg_size <= next_req.arg_size;
                req.left_align <= next_req.left_align;
                req.force_plus <= next_req.force_plus;
                req.space_sign <= next_req.space_sign;
                req.alternate_form <= next_req.alternate_form;
                req.zero_pad <= next_req.zero_pad;
                req.field_width <= next_req.field_width;
                req.precision <= next_req.precision;
            end
        end
    end

    // Character receiver: picks a new random stall style whenever the current one runs out
    int        rx_cycle;
    int        style_left;
    rx_style_t rx_style;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text.ready <= 1'b0;
            rx_cycle <= 0;
            style_left <= 0;
            rx_style <= RX_STREAM;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if ((rx_cycle >= HOLD_A_START && rx_cycle < HOLD_A_START + HOLD_LEN) ||
                (rx_cycle >= HOLD_B_START && rx_cycle < HOLD_B_START + HOLD_LEN))
                text.ready <= 1'b0;
            else
            begin
                if (style_left == 0)
                begin
                    rx_style <= rx_style_t'($urandom_range(0, 3));
                    style_left <= $urandom_range(50, 300);
                end
                else
                    style_left <= style_left - 1;
                case (rx_style)
                    RX_STREAM:   text.ready <= 1'b1;
                    RX_COIN:     text.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   text.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: text.ready <= (rx_cycle[2:0] < 3'd5);
                    default:     text.ready <= 1'b1;
                endcase
            end
        end
    end

    // Monitor: predict on each request transfer, then check each character transfer
    conv_req_t  seen_req;
    text_beat_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                seen_req.mode = req.mode;
                seen_req.value = req.value;
                seen_req.arg_size = req.arg_size;
                seen_req.left_align = req.left_align;
                seen_req.force_plus = req.force_plus;
                seen_req.space_sign = req.space_sign;
                seen_req.alternate_form = req.alternate_form;
                seen_req.zero_pad = req.zero_pad;
                seen_req.field_width = req.field_width;
                seen_req.precision = req.precision;
                predict_field(seen_req);
            end
            if (text.valid && text.ready)
            begin
                if (expected_chars.size() == 0)
                    note_failure($sformatf("unexpected character: got 0x%02h last %0b",
                                           text.character, text.last));
                else
                begin
                    want = expected_chars.pop_front();
                    if (text.character !== want.character)
                        note_failure($sformatf("character %0d: expected 0x%02h, got 0x%02h",
                                               char_index, want.character, text.character));
                    if (text.last !== want.last)
                        note_failure($sformatf("character %0d last: expected %0b, got %0b",
                                               char_index, want.last, text.last));
                end
                char_index++;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((req.valid && req.ready) || (text.valid && text.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus, reset and end of run
    conv_req_t rnd;

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.mode = MODE_SDEC;
        req.value = '0;
        req.arg_size = '0;
        req.left_align = 1'b0;
        req.force_plus = 1'b0;
        req.space_sign = 1'b0;
        req.alternate_form = 1'b0;
        req.zero_pad = 1'b0;
        req.field_width = '0;
        req.precision = '0;
        text.ready = 1'b0;
        fail_count = 0;
        report_count = 0;
        char_index = 0;

        // Directed: field extremes, every mode and the corner cases
        add_request(MODE_SDEC, 64'h8000_0000_0000_0000, 2'd3, F_NONE, 0, PREC_NONE);
        add_request(MODE_SDEC, 64'h1234_5678_9ABC_DEFF, 2'd0, F_NONE, 0, PREC_NONE);
        add_request(MODE_SDEC, 64'd42, 2'd2, F_PLUS | F_ZPAD, 10, PREC_NONE);
        add_request(MODE_SDEC, 64'd7, 2'd1, F_PLUS | F_SPACE, 0, PREC_NONE);
        add_request(MODE_SDEC, 64'd123, 2'd2, F_SPACE | F_LEFT, 8, 5);
        add_request(MODE_SDEC, 64'h8000, 2'd1, F_ZPAD, 12, PREC_NONE);
        add_request(MODE_SDEC, 64'd0, 2'd3, F_PLUS, 0, 0);
        add_request(MODE_SDEC, 64'hFFFF_FFFF_FFFF_FFFE, 2'd3, F_LEFT | F_ZPAD, 127, -64);
        add_request(MODE_UDEC, '1, 2'd3, F_NONE, 127, PREC_NONE);
        add_request(MODE_UDEC, 64'd0, 2'd2, F_NONE, 0, 0);
        add_request(MODE_UDEC, 64'd0, 2'd0, F_NONE, 5, 0);
        add_request(MODE_UDEC, 64'hFFFF_FFFF, 2'd2, F_ZPAD, 64, 63);
        add_request(MODE_OCT, 64'd0, 2'd3, F_ALT, 0, PREC_NONE);
        add_request(MODE_OCT, 64'd8, 2'd0, F_ALT, 0, 5);
        add_request(MODE_OCT, 64'd0, 2'd1, F_ALT, 0, 0);
        add_request(MODE_OCT, '1, 2'd3, F_ALT | F_ZPAD, 30, PREC_NONE);
        add_request(MODE_HEXL, 64'hDEAD_BEEF, 2'd2, F_ALT | F_ZPAD, 20, PREC_NONE);
        add_request(MODE_HEXL, 64'd0, 2'd3, F_ALT, 6, PREC_NONE);
        add_request(MODE_HEXL, 64'hABC, 2'd3, F_NONE, 0, 63);
        add_request(MODE_HEXU, '1, 2'd3, F_ALT, 64, 60);
        add_request(MODE_PTR, 64'd0, 2'd0, F_NONE, 0, PREC_NONE);
        add_request(MODE_PTR, 64'd0, 2'd2, F_NONE, 0, 0);
        add_request(MODE_PTR, 64'h7FFF_0000_1234, 2'd0, F_ZPAD, 30, PREC_NONE);
        add_request(MODE_SPARE_A, 64'hFF, 2'd0, F_PLUS | F_ALT, 4, PREC_NONE);
        add_request(MODE_SPARE_B, 64'h8000_0000, 2'd2, F_SPACE, 0, 2);

        // Random requests, mostly narrow fields
        for (int k = 0; k < RANDOM_REQS; k++)
        begin
            rnd.mode = ($urandom_range(0, 15) < 14) ? 3'($urandom_range(0, 5))
                                                    : 3'($urandom_range(6, 7));
            rnd.arg_size = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0: rnd.value = {$urandom, $urandom};
                1: rnd.value = 64'($urandom_range(0, 20));
                2: rnd.value = {$urandom, $urandom} >> $urandom_range(0, 63);
                3: rnd.value = 64'd1 << $urandom_range(0, 63);
                default: rnd.value = ~64'($urandom_range(0, 5));
            endcase
            {rnd.left_align, rnd.force_plus, rnd.space_sign, rnd.alternate_form,
             rnd.zero_pad} = 5'($urandom);
            rnd.field_width = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 24))
                                                          : 7'($urandom_range(0, 127));
            case ($urandom_range(0, 3))
                0, 1: rnd.precision = 7'($urandom_range(64, 127));
                2: rnd.precision = 7'($urandom_range(0, 12));
                default: rnd.precision = 7'($urandom_range(0, 63));
            endcase
            pending_reqs.push_back(rnd);
            // Hold the sender until all outstanding characters are out
            pending_drain.push_back(k == 0 || k == 90);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all requests to go out and all characters to come back
        while (pending_reqs.size() != 0 || req.valid || expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expected_chars.size() != 0)
            note_failure($sformatf("%0d expected characters never arrived",
                                   expected_chars.size()));
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
